/* src/tgsw_pkg.sv */
// Shared types, constants, font table and helpers for the text glyph stream writer.
package tgsw_pkg;

	localparam int DISPLAY_COLUMNS_DEF = 84;
	localparam int BANK_ROWS_DEF       = 6;
	localparam int GLYPH_COLS          = 5;
	localparam int CUSTOM_SLOTS        = 32;
	localparam int GLYPH_ENTRIES       = GLYPH_COLS * CUSTOM_SLOTS;
	localparam int QUEUE_DEPTH         = 2;

	localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
	localparam logic [7:0] CMD_SET_COL     = 8'h80;
	localparam logic [7:0] CMD_SET_BANK    = 8'h40;
	localparam logic [7:0] BLANK_COL       = 8'h00;
	localparam logic [2:0] SPACER_COL      = 3'd5;
	localparam logic [2:0] PIDX_LIMIT      = 3'd5;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_CURSOR = 2'd1,
		OP_DEFINE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_ROM    = 2'd0,
		KIND_CUSTOM = 2'd1,
		KIND_CMD    = 2'd2,
		KIND_DEFINE = 2'd3
	} kind_t;

	// one decoded item as it sits in the queue
	typedef struct packed {
		kind_t      kind;
		logic [6:0] code;
		logic [7:0] addr;         // glyph store base (custom) or entry (define)
		logic [7:0] first_byte;   // command byte or define pattern
		logic [7:0] second_byte;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	// five columns packed with column 0 in the top byte
	localparam logic [39:0] FONT_ROM [96] = '{
		40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
		40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
		40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
		40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
		40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
		40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
		40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
		40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
	};

	function automatic logic [7:0] font_col(input logic [6:0] idx, input logic [2:0] col);
		logic [39:0] glyph;
		logic [7:0]  res;
		glyph = FONT_ROM[idx];
		case (col)
			3'd0:    res = glyph[39:32];
			3'd1:    res = glyph[31:24];
			3'd2:    res = glyph[23:16];
			3'd3:    res = glyph[15:8];
			3'd4:    res = glyph[7:0];
			default: res = BLANK_COL;
		endcase
		return res;
	endfunction

	// remainder by shift-and-subtract, eight narrow steps
	function automatic logic [7:0] mod_u8(input logic [7:0] value, input logic [7:0] divisor);
		logic [15:0] rem;
		logic [15:0] dshift;
		rem = {8'd0, value};
		for (int k = 7; k >= 0; k--) begin
			dshift = {8'd0, divisor} << k;
			if (rem >= dshift)
				rem = rem - dshift;
		end
		return rem[7:0];
	endfunction

	// slot * 5 as shift and add
	function automatic logic [7:0] slot_base(input logic [4:0] slot);
		return {1'b0, slot, 2'b00} + {3'b000, slot};
	endfunction

endpackage

/* src/tgsw_ifs.sv */
// Channel interfaces: request items in, display bytes out.
interface tgsw_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] code;
	logic [7:0] target_col;
	logic [7:0] target_bank;
	logic [2:0] pattern_index;
	logic [7:0] pattern;

	modport source (output valid, operation, code, target_col, target_bank,
		pattern_index, pattern, input ready);
	modport sink (input valid, operation, code, target_col, target_bank,
		pattern_index, pattern, output ready);
endinterface

interface tgsw_lcd_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;

	modport source (output valid, out_byte, is_data, last, input ready);
	modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

/* src/text_glyph_stream_writer.sv */
// Top level: text front end for a bank-addressed monochrome LCD.
//
//   port  dir   item                                   handshake
//   req   in    operation, code, target, pattern       valid/ready
//   lcd   out   out_byte, is_data, last                valid/ready
//
// A write item gives six bytes, a set-cursor item two bytes; a define item only writes the
// glyph store in the back end, and dropped items are taken by the front without output.
// The back end's byte sequencer, one byte per cycle while lcd is ready, sets the rate;
// the first byte shows after accept via the queue write, then the output register.
// Reset clears cursor, queue, glyph valid bits and the output stage.
// A stalled lcd side holds its byte while the front keeps filling the two-entry queue.
module text_glyph_stream_writer #(
	parameter int DISPLAY_COLUMNS = tgsw_pkg::DISPLAY_COLUMNS_DEF,
	parameter int BANK_ROWS       = tgsw_pkg::BANK_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tgsw_req_if.sink    req,
	tgsw_lcd_if.source  lcd
);
	tgsw_pkg::push_t  push;
	tgsw_pkg::entry_t head;
	logic             push_ready, head_valid, pop;

	tgsw_front #(
		.DISPLAY_COLUMNS (DISPLAY_COLUMNS),
		.BANK_ROWS       (BANK_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_ready (push_ready),
		.push       (push)
	);

	tgsw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tgsw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.lcd        (lcd)
	);

endmodule

/* src/tgsw_front.sv */
// Front end: accepts request items, tracks the cursor, decodes into queue entries.
module tgsw_front #(
	parameter int DISPLAY_COLUMNS = tgsw_pkg::DISPLAY_COLUMNS_DEF,
	parameter int BANK_ROWS       = tgsw_pkg::BANK_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tgsw_req_if.sink          req,
	input  logic              push_ready,
	output tgsw_pkg::push_t   push
);
	localparam int COL_W  = $clog2(DISPLAY_COLUMNS);
	localparam int BANK_W = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
	localparam logic [COL_W:0]  COLS_N  = (COL_W + 1)'(DISPLAY_COLUMNS);
	localparam logic [BANK_W:0] BANKS_N = (BANK_W + 1)'(BANK_ROWS);
	localparam logic [COL_W:0]  ADVANCE = (COL_W + 1)'(6);

	logic [COL_W-1:0]  col_q, col_nx;
	logic [BANK_W-1:0] bank_q, bank_nx;
	logic [COL_W:0]    col_sum;
	logic [COL_W-1:0]  col_adv;
	logic [BANK_W:0]   bank_sum;
	logic [BANK_W-1:0] bank_adv;
	logic [COL_W-1:0]  tcol;
	logic [BANK_W-1:0] tbank;
	logic              accept;

	assign req.ready = push_ready;
	assign accept    = req.valid && push_ready;

	assign col_sum  = {1'b0, col_q} + ADVANCE;
	assign col_adv  = (col_sum >= COLS_N) ? COL_W'(col_sum - COLS_N) : col_sum[COL_W-1:0];
	assign bank_sum = {1'b0, bank_q} + (BANK_W + 1)'(1);
	assign bank_adv = (bank_sum == BANKS_N) ? '0 : bank_sum[BANK_W-1:0];

	assign tcol  = COL_W'(tgsw_pkg::mod_u8(req.target_col, 8'(DISPLAY_COLUMNS)));
	assign tbank = BANK_W'(tgsw_pkg::mod_u8(req.target_bank, 8'(BANK_ROWS)));

	always_comb begin
		col_nx              = col_q;
		bank_nx             = bank_q;
		push.valid          = 1'b0;
		push.entry.kind     = tgsw_pkg::KIND_ROM;
		push.entry.code     = req.code[6:0];
		push.entry.addr     = '0;
		push.entry.first_byte  = tgsw_pkg::BLANK_COL;
		push.entry.second_byte = tgsw_pkg::BLANK_COL;
		case (tgsw_pkg::op_t'(req.operation))
			tgsw_pkg::OP_WRITE: begin
				if (!req.code[7]) begin
					push.valid = accept;
					if (req.code < tgsw_pkg::FIRST_PRINTABLE) begin
						push.entry.kind = tgsw_pkg::KIND_CUSTOM;
						push.entry.addr = tgsw_pkg::slot_base(req.code[4:0]);
					end
					col_nx = col_adv;
					if (col_adv == '0)
						bank_nx = bank_adv;
				end
			end
			tgsw_pkg::OP_CURSOR: begin
				push.valid             = accept;
				push.entry.kind        = tgsw_pkg::KIND_CMD;
				push.entry.first_byte  = tgsw_pkg::CMD_SET_COL | 8'(tcol);
				push.entry.second_byte = tgsw_pkg::CMD_SET_BANK | 8'(tbank);
				col_nx  = tcol;
				bank_nx = tbank;
			end
			tgsw_pkg::OP_DEFINE: begin
				if (req.code < 8'(tgsw_pkg::CUSTOM_SLOTS) &&
				    req.pattern_index < tgsw_pkg::PIDX_LIMIT) begin
					push.valid            = accept;
					push.entry.kind       = tgsw_pkg::KIND_DEFINE;
					push.entry.addr       = tgsw_pkg::slot_base(req.code[4:0]) +
						{5'd0, req.pattern_index};
					push.entry.first_byte = req.pattern;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			bank_q <= '0;
		end else if (accept) begin
			col_q  <= col_nx;
			bank_q <= bank_nx;
		end
	end

endmodule

/* src/tgsw_queue.sv */
// Short FIFO of decoded entries between front and back.
module tgsw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  tgsw_pkg::push_t   push,
	output logic              push_ready,
	input  logic              pop,
	output logic              head_valid,
	output tgsw_pkg::entry_t  head
);
	localparam int DEPTH = tgsw_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tgsw_pkg::entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q < CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

/* src/tgsw_back.sv */
// Back end: walks queue entries column by column, owns the custom glyph store.
module tgsw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  tgsw_pkg::entry_t  head,
	output logic              pop,
	tgsw_lcd_if.source        lcd
);
	localparam int ENTRIES = tgsw_pkg::GLYPH_ENTRIES;
	localparam int ADDR_W  = $clog2(ENTRIES);

	logic [7:0]        glyph_mem_q [ENTRIES];
	logic [ENTRIES-1:0] entry_valid_q;

	logic [2:0]        col_q;
	logic              s2_ready, issue, define_now;
	logic [7:0]        byte_nx;
	logic              data_nx, last_nx, custom_nx;
	logic [ADDR_W-1:0] rd_addr, wr_addr;

	logic              valid_s2;
	logic [7:0]        byte_s2;
	logic              data_s2, last_s2, custom_s2;
	logic [7:0]        mem_rd_s2;
	logic              ent_ok_s2;

	assign s2_ready   = !valid_s2 || lcd.ready;
	assign define_now = head_valid && head.kind == tgsw_pkg::KIND_DEFINE;
	assign issue      = head_valid && head.kind != tgsw_pkg::KIND_DEFINE && s2_ready;
	assign pop        = define_now || (issue && last_nx);
	assign rd_addr    = ADDR_W'(head.addr + {5'd0, col_q});
	assign wr_addr    = ADDR_W'(head.addr);

	always_comb begin
		byte_nx   = tgsw_pkg::BLANK_COL;
		data_nx   = 1'b1;
		last_nx   = col_q == tgsw_pkg::SPACER_COL;
		custom_nx = 1'b0;
		case (head.kind)
			tgsw_pkg::KIND_ROM: begin
				if (!last_nx)
					byte_nx = tgsw_pkg::font_col(head.code - 7'(tgsw_pkg::FIRST_PRINTABLE), col_q);
			end
			tgsw_pkg::KIND_CUSTOM: begin
				custom_nx = !last_nx;
			end
			tgsw_pkg::KIND_CMD: begin
				data_nx = 1'b0;
				last_nx = col_q[0];
				byte_nx = col_q[0] ? head.second_byte : head.first_byte;
			end
			default: ;
		endcase
	end

	// glyph store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (define_now)
			glyph_mem_q[wr_addr] <= head.first_byte;
		if (issue && custom_nx)
			mem_rd_s2 <= glyph_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			byte_s2   <= byte_nx;
			data_s2   <= data_nx;
			last_s2   <= last_nx;
			custom_s2 <= custom_nx;
			ent_ok_s2 <= custom_nx && entry_valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			col_q         <= '0;
			valid_s2      <= 1'b0;
		end else begin
			if (define_now)
				entry_valid_q[wr_addr] <= 1'b1;
			if (issue)
				col_q <= last_nx ? 3'd0 : col_q + 3'd1;
			if (s2_ready)
				valid_s2 <= issue;
		end
	end

	assign lcd.valid    = valid_s2;
	assign lcd.out_byte = custom_s2 ? (ent_ok_s2 ? mem_rd_s2 : tgsw_pkg::BLANK_COL) : byte_s2;
	assign lcd.is_data  = data_s2;
	assign lcd.last     = last_s2;

endmodule

/* tb/text_glyph_stream_writer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for text_glyph_stream_writer: directed requests, a burst of writes, then random ones.
module text_glyph_stream_writer_tb;

	localparam int         HALF_PERIOD   = 5;
	localparam int         COLS          = tgsw_pkg::DISPLAY_COLUMNS_DEF;
	localparam int         BANKS         = tgsw_pkg::BANK_ROWS_DEF;
	localparam int         LONG_HOLD     = 80;
	localparam int         BURST_WRITES  = 12;
	localparam int         RANDOM_ITEMS  = 60;
	localparam int         DRAIN_CYCLES  = 20;
	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam logic [7:0] FIRST_HIGH    = 8'h80;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] code;
		logic [7:0] target_col;
		logic [7:0] target_bank;
		logic [2:0] pattern_index;
		logic [7:0] pattern;
	} request_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
	} lcd_byte_t;

	// typed_n < 0: take the bytes from the predictor
	typedef struct {
		request_t    req;
		int          typed_n;
		logic [47:0] typed_bytes;
	} table_row_t;

	// column 0 in the top byte
	localparam logic [39:0] GLYPHS [96] = '{
		40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
		40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
		40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
		40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
		40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
		40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
		40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
		40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
	};

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches = 0;
	bit   calm = 1'b0;
	bit   lcd_hold_req = 1'b0;

	lcd_byte_t  lcd_bytes_due[$];
	lcd_byte_t  next_bytes[$];
	table_row_t directed[$];
	lcd_byte_t  due;

	// predictor state
	logic [6:0]  cursor_col;
	logic [2:0]  cursor_bank;
	logic [7:0]  glyph_store [tgsw_pkg::GLYPH_ENTRIES];
	logic [31:0] glyph_defined;

	tgsw_req_if req_ch ();
	tgsw_lcd_if lcd_ch ();

	text_glyph_stream_writer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.lcd    (lcd_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// fills next_bytes with the bytes one request causes and updates the state
	task automatic predict_request(input request_t r);
		logic [39:0] glyph;
		int          base;
		next_bytes.delete();
		case (r.operation)
			tgsw_pkg::OP_WRITE: begin
				if (r.code < FIRST_HIGH) begin
					base = r.code[4:0] * tgsw_pkg::GLYPH_COLS;
					if (r.code >= tgsw_pkg::FIRST_PRINTABLE)
						glyph = GLYPHS[r.code - tgsw_pkg::FIRST_PRINTABLE];
					else if (glyph_defined[r.code[4:0]])
						glyph = {glyph_store[base], glyph_store[base + 1], glyph_store[base + 2],
							glyph_store[base + 3], glyph_store[base + 4]};
					else
						glyph = '0;
					for (int k = 0; k < tgsw_pkg::GLYPH_COLS; k++)
						next_bytes.push_back('{out_byte: glyph[39 - 8 * k -: 8],
							is_data: 1'b1, last: 1'b0});
					next_bytes.push_back('{out_byte: tgsw_pkg::BLANK_COL, is_data: 1'b1,
						last: 1'b1});
					cursor_col = 7'((cursor_col + 6) % COLS);
					if (cursor_col == 0)
						cursor_bank = 3'((cursor_bank + 1) % BANKS);
				end
			end
			tgsw_pkg::OP_CURSOR: begin
				cursor_col  = 7'(r.target_col % COLS);
				cursor_bank = 3'(r.target_bank % BANKS);
				next_bytes.push_back('{out_byte: tgsw_pkg::CMD_SET_COL | {1'b0, cursor_col},
					is_data: 1'b0, last: 1'b0});
				next_bytes.push_back('{out_byte: tgsw_pkg::CMD_SET_BANK | {5'b0, cursor_bank},
					is_data: 1'b0, last: 1'b1});
			end
			tgsw_pkg::OP_DEFINE: begin
				if (r.code < tgsw_pkg::CUSTOM_SLOTS && r.pattern_index < tgsw_pkg::PIDX_LIMIT) begin
					glyph_store[r.code * tgsw_pkg::GLYPH_COLS + r.pattern_index] = r.pattern;
					glyph_defined[r.code[4:0]] = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic pause_sender();
		int n;
		n = idle_cycles();
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// offer one item, wait for accept, queue what it should produce
	task automatic apply_request(input request_t r, input int typed_n,
			input logic [47:0] typed_bytes);
		req_ch.valid         <= 1'b1;
		req_ch.operation     <= r.operation;
		req_ch.code          <= r.code;
		req_ch.target_col    <= r.target_col;
		req_ch.target_bank   <= r.target_bank;
		req_ch.pattern_index <= r.pattern_index;
		req_ch.pattern       <= r.pattern;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predict_request(r);
		if (typed_n < 0) begin
			foreach (next_bytes[k])
				lcd_bytes_due.push_back(next_bytes[k]);
		end else begin
			for (int k = 0; k < typed_n; k++)
				lcd_bytes_due.push_back('{out_byte: typed_bytes[47 - 8 * k -: 8],
					is_data: r.operation == tgsw_pkg::OP_WRITE, last: k == typed_n - 1});
		end
		pause_sender();
	endtask

	task automatic add_row(input logic [1:0] op, input logic [7:0] code,
			input logic [7:0] tcol, input logic [7:0] tbank, input logic [2:0] pidx,
			input logic [7:0] pat, input int n, input logic [47:0] bytes);
		table_row_t row;
		row.req         = '{op, code, tcol, tbank, pidx, pat};
		row.typed_n     = n;
		row.typed_bytes = bytes;
		directed.push_back(row);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		lcd_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (lcd_hold_req) begin
				lcd_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				lcd_hold_req = 1'b0;
			end else begin
				n = idle_cycles();
				if (n > 0) begin
					lcd_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				lcd_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && lcd_ch.valid && lcd_ch.ready) begin
			if (lcd_bytes_due.size() == 0) begin
				$error("out_byte: expected nothing, got %02h", lcd_ch.out_byte);
				mismatches++;
			end else begin
				due = lcd_bytes_due.pop_front();
				if (lcd_ch.out_byte !== due.out_byte) begin
					$error("out_byte: expected %02h, got %02h", due.out_byte, lcd_ch.out_byte);
					mismatches++;
				end
				if (lcd_ch.is_data !== due.is_data) begin
					$error("is_data: expected %0b, got %0b", due.is_data, lcd_ch.is_data);
					mismatches++;
				end
				if (lcd_ch.last !== due.last) begin
					$error("last: expected %0b, got %0b", due.last, lcd_ch.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		request_t r;
		int       counted;
		int       pick;
		bit       effective;

		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.operation     = tgsw_pkg::OP_WRITE;
		req_ch.code          = '0;
		req_ch.target_col    = '0;
		req_ch.target_bank   = '0;
		req_ch.pattern_index = '0;
		req_ch.pattern       = '0;
		cursor_col           = '0;
		cursor_bank          = '0;
		glyph_defined        = '0;
		foreach (glyph_store[i])
			glyph_store[i] = '0;

		add_row(tgsw_pkg::OP_WRITE,  8'h41, 8'd0,   8'd0,   3'd0, 8'h00, 6, 48'h7e1111117e00);
		add_row(tgsw_pkg::OP_WRITE,  8'h20, 8'd0,   8'd0,   3'd0, 8'h00, 6, 48'h0);
		add_row(tgsw_pkg::OP_WRITE,  8'h7f, 8'd0,   8'd0,   3'd0, 8'h00, 6, 48'h0);
		// slot never defined: blank glyph
		add_row(tgsw_pkg::OP_WRITE,  8'h00, 8'd0,   8'd0,   3'd0, 8'h00, 6, 48'h0);
		add_row(tgsw_pkg::OP_WRITE,  8'h80, 8'd0,   8'd0,   3'd0, 8'h00, 0, 48'h0);
		add_row(tgsw_pkg::OP_WRITE,  8'hff, 8'd0,   8'd0,   3'd0, 8'h00, 0, 48'h0);
		add_row(tgsw_pkg::OP_CURSOR, 8'h00, 8'd83,  8'd5,   3'd0, 8'h00, 2, 48'hd34500000000);
		add_row(tgsw_pkg::OP_CURSOR, 8'hff, 8'd255, 8'd255, 3'd7, 8'hff, 2, 48'h834300000000);
		add_row(tgsw_pkg::OP_CURSOR, 8'h00, 8'd84,  8'd6,   3'd0, 8'h00, 2, 48'h804000000000);
		add_row(tgsw_pkg::OP_WRITE,  8'h7e, 8'd0,   8'd0,   3'd0, 8'h00, -1, 48'h0);
		add_row(tgsw_pkg::OP_DEFINE, 8'd31, 8'd0,   8'd0,   3'd0, 8'hff, 0, 48'h0);
		add_row(tgsw_pkg::OP_DEFINE, 8'd31, 8'd0,   8'd0,   3'd4, 8'h81, 0, 48'h0);
		// partly defined slot: unwritten columns read zero
		add_row(tgsw_pkg::OP_WRITE,  8'h1f, 8'd0,   8'd0,   3'd0, 8'h00, 6, 48'hff0000008100);
		add_row(tgsw_pkg::OP_DEFINE, 8'd32, 8'd0,   8'd0,   3'd0, 8'haa, 0, 48'h0);
		add_row(tgsw_pkg::OP_DEFINE, 8'd0,  8'd0,   8'd0,   3'd5, 8'h55, 0, 48'h0);
		add_row(tgsw_pkg::OP_DEFINE, 8'd0,  8'd0,   8'd0,   3'd7, 8'hff, 0, 48'h0);
		add_row(tgsw_pkg::OP_WRITE,  8'h00, 8'd0,   8'd0,   3'd0, 8'h00, 6, 48'h0);
		add_row(OP_UNUSED,           8'h41, 8'd12,  8'd3,   3'd2, 8'h3c, 0, 48'h0);
		add_row(tgsw_pkg::OP_CURSOR, 8'h00, 8'd78,  8'd5,   3'd0, 8'h00, 2, 48'hce4500000000);
		// column and bank both wrap here
		add_row(tgsw_pkg::OP_WRITE,  8'h41, 8'd0,   8'd0,   3'd0, 8'h00, -1, 48'h0);
		add_row(tgsw_pkg::OP_WRITE,  8'h21, 8'd0,   8'd0,   3'd0, 8'h00, -1, 48'h0);
		add_row(tgsw_pkg::OP_DEFINE, 8'd5,  8'd0,   8'd0,   3'd2, 8'h3c, 0, 48'h0);
		add_row(tgsw_pkg::OP_WRITE,  8'h05, 8'd0,   8'd0,   3'd0, 8'h00, 6, 48'h00003c000000);
		add_row(tgsw_pkg::OP_CURSOR, 8'h00, 8'd0,   8'd0,   3'd0, 8'h00, 2, 48'h804000000000);
		add_row(tgsw_pkg::OP_DEFINE, 8'hff, 8'd0,   8'd0,   3'd3, 8'h00, 0, 48'h0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			apply_request(directed[i].req, directed[i].typed_n, directed[i].typed_bytes);

		// back-to-back writes against a held-off receiver, then drain fully
		lcd_hold_req = 1'b1;
		calm = 1'b1;
		for (int k = 0; k < BURST_WRITES; k++) begin
			r = '0;
			r.operation = tgsw_pkg::OP_WRITE;
			r.code = 8'($urandom_range(0, 127));
			apply_request(r, -1, '0);
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;
		while (lcd_bytes_due.size() != 0)
			@(posedge clk);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			calm = counted >= 40 && counted < 50;
			r.target_col    = 8'($urandom);
			r.target_bank   = 8'($urandom);
			r.pattern       = 8'($urandom);
			r.pattern_index = 3'($urandom_range(0, 7));
			r.code          = 8'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r.operation = tgsw_pkg::OP_WRITE;
				pick = $urandom_range(0, 99);
				if (pick < 60)
					r.code = 8'($urandom_range(32, 127));
				else if (pick < 85)
					r.code = 8'($urandom_range(0, 31));
			end else if (pick < 65) begin
				r.operation = tgsw_pkg::OP_CURSOR;
			end else if (pick < 92) begin
				r.operation = tgsw_pkg::OP_DEFINE;
				if ($urandom_range(0, 99) < 80) begin
					r.code          = 8'($urandom_range(0, 31));
					r.pattern_index = 3'($urandom_range(0, 4));
				end
			end else begin
				r.operation = OP_UNUSED;
			end
			effective = (r.operation == tgsw_pkg::OP_WRITE && r.code < FIRST_HIGH) ||
				r.operation == tgsw_pkg::OP_CURSOR ||
				(r.operation == tgsw_pkg::OP_DEFINE && r.code < tgsw_pkg::CUSTOM_SLOTS &&
				r.pattern_index < tgsw_pkg::PIDX_LIMIT);
			apply_request(r, -1, '0);
			if (effective)
				counted++;
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		while (lcd_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
